// ----- hw/rtl/irwpq_pkg.sv -----
// ----------------------------------------------------------------------------
// IR wall proximity qualifier package
// Shared constants, types and the debounce step for the qualifier lanes.
// ----------------------------------------------------------------------------
package irwpq_pkg;

  localparam int DefaultChannels   = 5;
  localparam int DefaultAvgWindow  = 8;
  localparam int DefaultSampleBits = 16;

  // fixed field widths
  localparam int SampleW  = 16;
  localparam int FlagCntW = 4;
  localparam int CfgIdxW  = 4;

  localparam logic [FlagCntW-1:0] NearLimit  = FlagCntW'(10);
  localparam logic [FlagCntW-1:0] CloseLimit = FlagCntW'(8);
  localparam logic [FlagCntW-1:0] CloseHold  = FlagCntW'(10);

  localparam logic [SampleW-1:0] NearThrReset  = SampleW'(600);
  localparam logic [SampleW-1:0] CloseThrReset = SampleW'(300);

  typedef struct packed {
    logic accept;   // input beat taken, stage 1 state updates
    logic advance;  // pipeline moves
    logic fire;     // stage 3 holds an item and moves
  } ctrl_t;

  typedef struct packed {
    logic [FlagCntW-1:0] up;
    logic [FlagCntW-1:0] down;
    logic                flag;
  } debounce_t;

  typedef struct packed {
    logic               near;
    logic               close;
    logic [SampleW-1:0] excess;
  } lane_res_t;

  function automatic debounce_t debounce_step(input debounce_t           s,
                                              input logic                over,
                                              input logic [FlagCntW-1:0] limit,
                                              input logic [FlagCntW-1:0] hold);
    debounce_t n;
    n = s;
    if (over) begin
      n.up   = s.up + FlagCntW'(1);
      n.down = '0;
      if (n.up > limit) begin
        n.flag = 1'b1;
        n.up   = hold;
      end
    end else begin
      n.up   = '0;
      n.down = s.down + FlagCntW'(1);
      if (n.down > limit) begin
        n.flag = 1'b0;
        n.down = hold;
      end
    end
    return n;
  endfunction

endpackage

// ----- hw/rtl/irwpq_lane.sv -----
// ----------------------------------------------------------------------------
// IR wall proximity qualifier lane
// One sensor channel: difference, bias, moving average, debounced flags.
// ----------------------------------------------------------------------------
module irwpq_lane #(
  parameter int AVG_WINDOW  = irwpq_pkg::DefaultAvgWindow,
  parameter int SAMPLE_BITS = irwpq_pkg::DefaultSampleBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  irwpq_pkg::ctrl_t              ctrl_i,
  input  logic [irwpq_pkg::SampleW-1:0] dark_i,
  input  logic [irwpq_pkg::SampleW-1:0] lit_i,
  input  logic [irwpq_pkg::SampleW-1:0] near_thr_i,
  input  logic [irwpq_pkg::SampleW-1:0] close_thr_i,
  output irwpq_pkg::lane_res_t          res_o
);

  localparam int LogW   = $clog2(AVG_WINDOW);
  localparam int SumW   = SAMPLE_BITS + LogW;
  localparam int ShiftW = SumW + LogW;
  localparam int ProdW  = 2 * SumW + 1;
  // exact floor division by the window depth over the whole sum range
  localparam logic [SumW:0] Recip =
    (SumW+1)'(((64'd1 << ShiftW) + 64'(AVG_WINDOW) - 64'd1) / 64'(AVG_WINDOW));

  logic [SAMPLE_BITS-1:0] dark, lit, diff;
  logic [SAMPLE_BITS-1:0] win_q [AVG_WINDOW];
  logic [SumW-1:0]        sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] bias_q, bias_d;
  logic [ProdW-1:0]       prod_q;
  logic [SAMPLE_BITS-1:0] bias2_q;
  logic [SAMPLE_BITS-1:0] avg, excess;
  irwpq_pkg::debounce_t   near_q, near_d, close_q, close_d;
  logic                   near_over, close_over;

  // stage 1: difference, bias, window
  assign dark   = dark_i[SAMPLE_BITS-1:0];
  assign lit    = lit_i[SAMPLE_BITS-1:0];
  assign diff   = (dark > lit) ? dark - lit : '0;
  assign bias_d = (bias_q > diff) ? diff : bias_q;
  assign sum_d  = sum_q + SumW'(diff) - SumW'(win_q[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < AVG_WINDOW; k++) win_q[k] <= '0;
      sum_q  <= '0;
      bias_q <= '1;
    end else if (ctrl_i.accept) begin
      for (int k = 0; k < AVG_WINDOW - 1; k++) win_q[k] <= win_q[k+1];
      win_q[AVG_WINDOW-1] <= diff;
      sum_q  <= sum_d;
      bias_q <= bias_d;
    end
  end

  // stage 2: reciprocal multiply
  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      prod_q  <= ProdW'(sum_q) * ProdW'(Recip);
      bias2_q <= bias_q;
    end
  end

  // stage 3: average, debounce, excess
  assign avg        = prod_q[ShiftW +: SAMPLE_BITS];
  assign near_over  = irwpq_pkg::SampleW'(avg) > near_thr_i;
  assign close_over = irwpq_pkg::SampleW'(avg) > close_thr_i;
  assign near_d     = irwpq_pkg::debounce_step(near_q, near_over,
                                               irwpq_pkg::NearLimit, irwpq_pkg::NearLimit);
  assign close_d    = irwpq_pkg::debounce_step(close_q, close_over,
                                               irwpq_pkg::CloseLimit, irwpq_pkg::CloseHold);
  assign excess     = (avg > bias2_q) ? avg - bias2_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q  <= '0;
      close_q <= '0;
    end else if (ctrl_i.fire) begin
      near_q  <= near_d;
      close_q <= close_d;
    end
  end

  assign res_o.near   = near_d.flag;
  assign res_o.close  = close_d.flag;
  assign res_o.excess = irwpq_pkg::SampleW'(excess);

endmodule

// ----- hw/rtl/irwpq_merge.sv -----
// ----------------------------------------------------------------------------
// IR wall proximity qualifier merge
// Packs lane results into one beat; output register with skid stage.
// ----------------------------------------------------------------------------
module irwpq_merge #(
  parameter int CHANNELS = irwpq_pkg::DefaultChannels,
  localparam int OutBits = CHANNELS * (2 + irwpq_pkg::SampleW),
  localparam int OutW    = ((OutBits + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  irwpq_pkg::lane_res_t res_i [CHANNELS],
  input  logic                 m_tready_i,
  output logic                 m_tvalid_o,
  output logic [OutW-1:0]      m_tdata_o,
  output logic                 skid_full_o
);

  logic [OutW-1:0] pack;
  logic [OutW-1:0] out_q, skid_q;
  logic            out_v_q, skid_v_q;

  always_comb begin
    pack = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      pack[c]                                          = res_i[c].near;
      pack[CHANNELS+c]                                 = res_i[c].close;
      pack[2*CHANNELS + irwpq_pkg::SampleW*c +: irwpq_pkg::SampleW] = res_i[c].excess;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_v_q && !m_tready_i) begin
      if (fire_i) skid_v_q <= 1'b1;
    end else if (skid_v_q) begin
      out_v_q  <= 1'b1;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q <= fire_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_q && !m_tready_i) begin
      if (fire_i) skid_q <= pack;
    end else if (skid_v_q) begin
      out_q <= skid_q;
    end else if (fire_i) begin
      out_q <= pack;
    end
  end

  assign m_tvalid_o  = out_v_q;
  assign m_tdata_o   = out_q;
  assign skid_full_o = skid_v_q;

endmodule

// ----- hw/rtl/ir_wall_proximity_qualifier.sv -----
// Pipeline: a result beat shows on m_axis_tvalid once its input beat has passed the window/sum,
// reciprocal multiply and output registers, in that order.
// Throughput: one beat per cycle while the skid stage is empty; each channel has its own lane,
// the sum is kept running and the average is a registered reciprocal multiply.
// Reset: averaging windows and sums clear to zero, bias to all ones, debounce
// counters and flags to far, near thresholds to 600 and close threshold to 300.
// ----------------------------------------------------------------------------
// IR wall proximity qualifier
// Five-lane infrared wall sensor averaging with bias removal and debounce.
// ----------------------------------------------------------------------------
module ir_wall_proximity_qualifier #(
  parameter int CHANNELS    = irwpq_pkg::DefaultChannels,
  parameter int AVG_WINDOW  = irwpq_pkg::DefaultAvgWindow,
  parameter int SAMPLE_BITS = irwpq_pkg::DefaultSampleBits,
  localparam int InW        = CHANNELS * 2 * irwpq_pkg::SampleW,
  localparam int OutBits    = CHANNELS * (2 + irwpq_pkg::SampleW),
  localparam int OutW       = ((OutBits + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [irwpq_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [irwpq_pkg::SampleW-1:0] cfg_data_i,
  // input beats
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [InW-1:0]                s_axis_tdata,  // dark_ch0, lit_ch0, ... dark_chN, lit_chN
  // result beats
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OutW-1:0]               m_axis_tdata   // near_flags, close_flags, excess_ch0..chN
);

  logic [irwpq_pkg::SampleW-1:0] near_thr_q [CHANNELS];
  logic [irwpq_pkg::SampleW-1:0] close_thr_q;
  irwpq_pkg::ctrl_t              ctrl;
  irwpq_pkg::lane_res_t          res [CHANNELS];
  logic                          v1_q, v2_q, skid_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) near_thr_q[c] <= irwpq_pkg::NearThrReset;
      close_thr_q <= irwpq_pkg::CloseThrReset;
    end else if (cfg_valid_i) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (cfg_index_i == irwpq_pkg::CfgIdxW'(c)) near_thr_q[c] <= cfg_data_i;
      end
      if (cfg_index_i == irwpq_pkg::CfgIdxW'(CHANNELS)) close_thr_q <= cfg_data_i;
    end
  end

  assign ctrl.advance  = !skid_full;
  assign ctrl.accept   = s_axis_tvalid && ctrl.advance;
  assign ctrl.fire     = v2_q && ctrl.advance;
  assign s_axis_tready = ctrl.advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (ctrl.advance) begin
      v1_q <= ctrl.accept;
      v2_q <= v1_q;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    irwpq_lane #(
      .AVG_WINDOW (AVG_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .dark_i     (s_axis_tdata[2*irwpq_pkg::SampleW*c +: irwpq_pkg::SampleW]),
      .lit_i      (s_axis_tdata[2*irwpq_pkg::SampleW*c + irwpq_pkg::SampleW +:
                                irwpq_pkg::SampleW]),
      .near_thr_i (near_thr_q[c]),
      .close_thr_i(close_thr_q),
      .res_o      (res[c])
    );
  end

  irwpq_merge #(
    .CHANNELS(CHANNELS)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (ctrl.fire),
    .res_i      (res),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .skid_full_o(skid_full)
  );

endmodule

// ----- hw/rtl/irwpq_checker.sv -----
// ----------------------------------------------------------------------------
// IR wall proximity qualifier checker
// Port-level checks on beat flow; bound to the top level.
// ----------------------------------------------------------------------------
module irwpq_checker #(
  parameter int InW  = 160,
  parameter int OutW = 96
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic [InW-1:0]  s_axis_tdata,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata
);

  logic [2:0] cnt_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // beats inside the block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != 3'd0)
    else $error("result beat without an input beat");

  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd5)
    else $error("too many beats in flight");

  a_in_data_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !$isunknown(s_axis_tdata))
    else $error("input beat accepted with unknown data");

endmodule

bind ir_wall_proximity_qualifier irwpq_checker #(
  .InW (InW),
  .OutW(OutW)
) u_irwpq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
